>>> sv/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue checker.
// Used by sv/spq_checker.sv.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// implication under clock and reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

>>> sv/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and state type.
// No dependencies.
`timescale 1ns / 1ps
package spq_pkg;
    localparam int unsigned QueueDepthDef   = 16;
    localparam int unsigned PayloadWidthDef = 32;
    localparam int unsigned PrioWidth       = 16;
    localparam int unsigned CountWidth      = 5;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REV = 2'd2,
        OP_CLR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_HEAD,
        S_ENDS,
        S_OUT
    } t_state;

    localparam logic [1:0] RegOrderedMode = 2'd0;
endpackage

>>> sv/spq_if.sv
// Valid/ready channel interfaces for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps
interface spq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] item_priority;
    logic [31:0]        item_payload;
    modport source (output valid, operation, item_priority, item_payload, input ready);
    modport sink   (input valid, operation, item_priority, item_payload, output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        removed_payload;
    logic signed [15:0] removed_priority;
    logic [4:0]         item_count;
    logic               is_empty;
    logic [31:0]        head_payload;
    logic signed [15:0] head_priority;
    logic [31:0]        tail_payload;
    logic signed [15:0] tail_priority;
    modport source (output valid, status, removed_payload, removed_priority, item_count,
                    is_empty, head_payload, head_priority, tail_payload, tail_priority,
                    input ready);
    modport sink   (input valid, status, removed_payload, removed_priority, item_count,
                    is_empty, head_payload, head_priority, tail_payload, tail_priority,
                    output ready);
endinterface

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: a memory-resident circular buffer with sorted insert.
// Depends on spq_pkg and spq_if.
`timescale 1ns / 1ps
// Items live in one memory (payload and priority side by side) used as a ring
// buffer addressed from a head pointer, so dequeue and reverse only move
// pointers and a direction bit. An ordered enqueue scans from the tail down,
// slot by slot (read, then write the slot one place further up) until it
// finds the insertion point, moving up every stored item with priority >= the
// new one; when every stored item qualifies, the new word then takes the head
// slot in an extra write step. Plain enqueue, ordered enqueue into an empty or
// full queue, dequeue, reverse and clear skip the scan. Every operation ends
// with the end-slot reads, head then tail, through the single read port. One
// word is in flight at a time; a new word is taken only once the output
// register holds no unaccepted result or that result is being accepted.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = spq_pkg::QueueDepthDef,
    parameter int unsigned PAYLOAD_WIDTH = spq_pkg::PayloadWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = PAYLOAD_WIDTH + PrioWidth;

    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;

    t_state r_state, n_state;
    logic          r_ordered, r_sort, n_sort;
    logic          r_rev, n_rev;          // 1: logical index runs downwards
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos, n_pos;          // logical index being scanned
    logic [1:0]    r_op;
    logic signed [PrioWidth-1:0] r_pri;
    logic [PAYLOAD_WIDTH-1:0]    r_pay;
    logic [1:0]    r_stat, n_stat;
    logic [EW-1:0] r_rem, n_rem;
    logic [EW-1:0] r_hd, n_hd;
    logic          r_ph, n_ph;            // end-read phase: 0 head, 1 tail
    logic          r_ovld, n_ovld;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic [CW-1:0] rd_l;

    // logical index to physical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic rev,
                                           input logic [CW-1:0] l);
        logic [AW:0] s;
        logic [AW:0] d;
        logic [AW:0] h;
        begin
            d = (AW+1)'(l);
            h = {1'b0, head};
            if (!rev) begin
                s = h + d;
                if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
            end else begin
                s = (h >= d) ? h - d : h + (AW+1)'(QUEUE_DEPTH) - d;
            end
            return s[AW-1:0];
        end
    endfunction

    assign pready = 1'b1;
    assign prdata = {31'd0, r_ordered};
    assign i_in.ready = (r_state == S_IDLE) && (!r_ovld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ordered <= 1'b0;
        else if (psel && penable && pwrite && paddr == RegOrderedMode)
            r_ordered <= pwdata[0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    logic signed [PrioWidth-1:0] rd_pri;
    assign rd_pri = r_rd[PrioWidth-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid && i_in.ready) begin
                unique case (t_op'(i_in.operation))
                    OP_ENQ: n_state = (r_cnt >= CW'(QUEUE_DEPTH)) ? S_ENDS
                                    : ((r_cnt != '0) && r_sort) ? S_SCAN : S_ENDS;
                    default: n_state = S_ENDS;
                endcase
            end
            S_SCAN: n_state = S_MOVE;
            S_MOVE: n_state = (r_pri > rd_pri) ? S_ENDS
                            : (r_pos == '0) ? S_HEAD : S_SCAN;
            S_HEAD: n_state = S_ENDS;
            S_ENDS: n_state = r_ph ? S_OUT : S_ENDS;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_sort = r_sort; n_rev = r_rev; n_head = r_head; n_cnt = r_cnt;
        n_pos = r_pos; n_stat = r_stat; n_rem = r_rem; n_hd = r_hd; n_ph = r_ph;
        n_ovld = r_ovld && !o_out.ready;
        rd_en = 1'b0; wr_en = 1'b0; rd_l = '0;
        wr_addr = '0; wr_data = {r_pay, r_pri};
        unique case (r_state)
            S_IDLE: begin
                n_ph = 1'b0;
                n_stat = ST_DONE; n_rem = '0;
                n_pos = r_cnt - CW'(1);
                rd_en = 1'b1; rd_l = r_cnt - CW'(1);
            end
            S_SCAN: begin
                rd_en = 1'b1; rd_l = r_pos;
            end
            S_MOVE: begin
                wr_en = 1'b1;
                wr_addr = phys(r_head, r_rev, r_pos + CW'(1));
                if (r_pri > rd_pri) n_cnt = r_cnt + CW'(1);
                else wr_data = r_rd;
                n_pos = r_pos - CW'(1);
            end
            S_HEAD: begin
                // every stored word has moved up one place: new word takes the head
                wr_en = 1'b1;
                wr_addr = phys(r_head, r_rev, '0);
                n_cnt = r_cnt + CW'(1);
            end
            S_ENDS: begin
                rd_en = 1'b1;
                rd_l = r_ph ? r_cnt - CW'(1) : '0;
                if (r_ph) n_hd = r_rd;
                n_ph = 1'b1;
            end
            S_OUT: n_ovld = 1'b1;
            default: ;
        endcase
        // operation side effects on entry
        if (r_state == S_IDLE && i_in.valid && i_in.ready) begin
            unique case (t_op'(i_in.operation))
                OP_ENQ: begin
                    if (r_cnt >= CW'(QUEUE_DEPTH)) n_stat = ST_FULL;
                    else if (r_cnt == '0 || !r_sort) begin
                        wr_en = 1'b1;
                        wr_addr = phys(r_head, r_rev, r_cnt);
                        wr_data = {PAYLOAD_WIDTH'(i_in.item_payload), i_in.item_priority};
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                OP_DEQ: begin
                    if (r_cnt == '0) n_stat = ST_EMPTY;
                    else begin
                        rd_en = 1'b1; rd_l = '0;
                        n_head = phys(r_head, r_rev, CW'(1));
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                OP_REV: begin
                    if (r_cnt != '0) begin
                        n_head = phys(r_head, r_rev, r_cnt - CW'(1));
                        n_rev = !r_rev;
                    end
                    n_sort = 1'b0;
                end
                default: begin
                    n_cnt = '0; n_sort = r_ordered;
                end
            endcase
        end
        if (r_state == S_ENDS && !r_ph && r_op == OP_DEQ && r_stat == ST_DONE)
            n_rem = r_rd;
        rd_addr = phys(r_head, r_rev, rd_l);
        // ENDS phase 0 reads the head slot; the last write is already in memory
        if (r_state == S_ENDS && !r_ph) rd_addr = phys(r_head, r_rev, '0);
    end

    // dequeue read happens in IDLE at old head; ENDS phase 0 re-reads the new
    // head, so the removed item is captured from the IDLE read here.
    logic r_deq_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sort <= 1'b0; r_rev <= 1'b0; r_head <= '0;
            r_cnt <= '0; r_ovld <= 1'b0; r_ph <= 1'b0; r_deq_cap <= 1'b0;
        end else begin
            r_state <= n_state; r_sort <= n_sort; r_rev <= n_rev; r_head <= n_head;
            r_cnt <= n_cnt; r_ovld <= n_ovld; r_ph <= n_ph;
            r_deq_cap <= r_state == S_IDLE && i_in.valid && i_in.ready
                         && i_in.operation == OP_DEQ && r_cnt != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos; r_stat <= n_stat; r_hd <= n_hd;
        r_rem <= r_deq_cap ? r_rd : n_rem;
        if (r_state == S_IDLE && i_in.valid && i_in.ready) begin
            r_op  <= i_in.operation;
            r_pri <= i_in.item_priority;
            r_pay <= PAYLOAD_WIDTH'(i_in.item_payload);
        end
    end

    // output register
    logic                     r_o_empty;
    logic [CW-1:0]            r_o_cnt;
    logic [EW-1:0]            r_o_hd, r_o_tl, r_o_rem;
    logic [1:0]               r_o_stat;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_o_cnt <= r_cnt; r_o_empty <= (r_cnt == '0);
            r_o_hd <= (r_cnt == '0) ? '0 : r_hd;
            r_o_tl <= (r_cnt == '0) ? '0 : r_rd;
            r_o_rem <= r_rem; r_o_stat <= r_stat;
        end
    end

    assign o_out.valid            = r_ovld;
    assign o_out.status           = r_o_stat;
    assign o_out.removed_payload  = 32'(r_o_rem[EW-1:PrioWidth]);
    assign o_out.removed_priority = r_o_rem[PrioWidth-1:0];
    assign o_out.item_count       = CountWidth'(r_o_cnt);
    assign o_out.is_empty         = r_o_empty;
    assign o_out.head_payload     = 32'(r_o_hd[EW-1:PrioWidth]);
    assign o_out.head_priority    = r_o_hd[PrioWidth-1:0];
    assign o_out.tail_payload     = 32'(r_o_tl[EW-1:PrioWidth]);
    assign o_out.tail_priority    = r_o_tl[PrioWidth-1:0];
endmodule

>>> sv/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"
module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_empty,
    input logic [4:0]  out_count,
    input logic [1:0]  out_status,
    input logic [31:0] out_rem
);
    import spq_pkg::*;
    `SPQ_ASSERT_IMP(a_empty_cnt, i_clk, i_rst_n, out_valid, out_empty == (out_count == 5'd0))
    `SPQ_ASSERT_IMP(a_empty_stat, i_clk, i_rst_n, out_valid && out_status == ST_EMPTY, out_empty)
    `SPQ_ASSERT_IMP(a_rem_zero, i_clk, i_rst_n, out_valid && out_status != ST_DONE, out_rem == 32'd0)
    `SPQ_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_empty(o_out.is_empty), .out_count(o_out.item_count),
    .out_status(o_out.status), .out_rem(o_out.removed_payload)
);
